[rtl/hfpr_pkg.sv]
package hfpr_pkg;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [7:0] HDR_SEED = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

    localparam logic [7:0] IDLE_RELOAD_RST = 8'd5;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
    } result_t;

endpackage

[rtl/hfpr_parser.sv]
module hfpr_parser
    import hfpr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    input  logic       opcode,
    input  logic [7:0] rx_byte,
    input  logic [7:0] timeout_reload,
    output logic       result_valid,
    output result_t    result
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_GOT_U = 3'd1,
        PH_GOT_N = 3'd2,
        PH_GOT_E = 3'd3,
        PH_LEN   = 3'd4,
        PH_TOKEN = 3'd5,
        PH_DATA  = 3'd6
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] checksum_reg, checksum_next;
    logic [7:0] countdown_reg, countdown_next;
    logic [7:0] remaining_dec;
    logic       hunt_u;

    assign hunt_u        = (rx_byte == CH_U);
    assign remaining_dec = remaining_reg - 8'd1;

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        checksum_next  = checksum_reg;
        countdown_next = countdown_reg;
        result_valid   = 1'b0;
        result         = '{kind: KIND_DATA, payload_byte: 8'h00};

        if (item_valid) begin
            if (opcode == OP_TICK) begin
                if (countdown_reg != 8'd0) begin
                    countdown_next = countdown_reg - 8'd1;
                end else begin
                    if (phase_reg == PH_DATA) begin
                        result_valid = 1'b1;
                        result       = '{kind: KIND_ABORT, payload_byte: 8'h00};
                    end
                    phase_next = PH_HUNT;
                end
            end else begin
                countdown_next = timeout_reload;
                case (phase_reg)
                    PH_GOT_U: begin
                        if (rx_byte == CH_N) begin
                            phase_next = PH_GOT_N;
                        end else begin
                            phase_next = hunt_u ? PH_GOT_U : PH_HUNT;
                            if (hunt_u) checksum_next = 8'h00;
                        end
                    end
                    PH_GOT_N: begin
                        if (rx_byte == CH_E) begin
                            phase_next = PH_GOT_E;
                        end else begin
                            phase_next = hunt_u ? PH_GOT_U : PH_HUNT;
                            if (hunt_u) checksum_next = 8'h00;
                        end
                    end
                    PH_GOT_E: begin
                        if (rx_byte == CH_R) begin
                            phase_next = PH_LEN;
                        end else begin
                            phase_next = hunt_u ? PH_GOT_U : PH_HUNT;
                            if (hunt_u) checksum_next = 8'h00;
                        end
                    end
                    PH_LEN: begin
                        remaining_next = rx_byte;
                        phase_next     = PH_TOKEN;
                    end
                    PH_TOKEN: begin
                        if (rx_byte == CH_COLON) begin
                            phase_next    = PH_DATA;
                            checksum_next = HDR_SEED ^ remaining_reg;
                        end else begin
                            phase_next = hunt_u ? PH_GOT_U : PH_HUNT;
                            if (hunt_u) checksum_next = 8'h00;
                        end
                    end
                    PH_DATA: begin
                        if (remaining_reg > 8'd1) begin
                            checksum_next = checksum_reg ^ rx_byte;
                            result_valid  = 1'b1;
                            result        = '{kind: KIND_DATA, payload_byte: rx_byte};
                        end
                        remaining_next = remaining_dec;
                        if (remaining_dec == 8'd0) begin
                            phase_next   = PH_HUNT;
                            result_valid = 1'b1;
                            result.kind  = (checksum_reg == rx_byte) ? KIND_GOOD : KIND_BAD;
                            result.payload_byte = 8'h00;
                        end
                    end
                    default: begin
                        phase_next = hunt_u ? PH_GOT_U : PH_HUNT;
                        if (hunt_u) checksum_next = 8'h00;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= 8'd0;
            checksum_reg  <= 8'd0;
            countdown_reg <= 8'd0;
        end else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            checksum_reg  <= checksum_next;
            countdown_reg <= countdown_next;
        end
    end

    a_result_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        result_valid |-> (phase_reg == PH_DATA))
        else $error("result outside payload phase");

    a_end_back_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (result_valid && (result.kind != KIND_DATA)) |=> (phase_reg == PH_HUNT))
        else $error("frame end did not return to hunting");

    a_byte_reloads_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && (opcode == OP_BYTE)) |=> (countdown_reg == $past(timeout_reload)))
        else $error("idle timer not reloaded by byte");

endmodule

[rtl/hfpr_skid.sv]
module hfpr_skid
    import hfpr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;
    logic    in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= in_fire;
                end
            end else if (in_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output");

    a_skid_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid filled without output stall");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output");

endmodule

[rtl/header_framed_packet_receiver_unit.sv]
// a result is registered in the output buffer before it appears on m_tvalid
// throughput: one input beat per cycle while s_tready is high, set by the parser update
// a two-entry output buffer keeps s_tready registered; it drops only after two
// results wait on a stalled m_tready
// reset: parser hunting for start, counters and checksum zero, idle reload 5
module header_framed_packet_receiver_unit
    import hfpr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,  // idle_timeout_reload
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // rx_byte
    input  logic       s_tuser,      // opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // payload_byte
    output logic [1:0] m_tuser       // kind
);

    logic [7:0] timeout_reload_reg;
    logic       item_valid;
    logic       result_valid;
    result_t    result;
    result_t    m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reload_reg <= IDLE_RELOAD_RST;
        end else if (cfg_wr_en) begin
            timeout_reload_reg <= cfg_wr_data;
        end
    end

    assign item_valid = s_tvalid && s_tready;

    hfpr_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (item_valid),
        .opcode         (s_tuser),
        .rx_byte        (s_tdata),
        .timeout_reload (timeout_reload_reg),
        .result_valid   (result_valid),
        .result         (result)
    );

    hfpr_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (result_valid),
        .in_ready (s_tready),
        .in_data  (result),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_result)
    );

    assign m_tdata = m_result.payload_byte;
    assign m_tuser = m_result.kind;

endmodule
